@@ hdl/packed_trit_store_unit_macros.svh @@
// ----------------------------------------------------------------------------
// packed trit store assertion macros
// concurrent check helpers, clocked on clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef PACKED_TRIT_STORE_UNIT_MACROS_SVH
`define PACKED_TRIT_STORE_UNIT_MACROS_SVH

// same-cycle implication
`define PTS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("packed trit store check failed");

// next-cycle implication
`define PTS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("packed trit store check failed");

`endif

@@ hdl/pts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_pkg
// shared types and constants of the packed trit store
// ----------------------------------------------------------------------------
package pts_pkg;

	localparam int CAPACITY_DEF = 1024;
	localparam int TRIT_W       = 2;
	localparam int FIELD_W      = 11;

	localparam logic [TRIT_W-1:0] TRIT_UNKNOWN = 2'd0;
	localparam logic [TRIT_W-1:0] TRIT_TRUE    = 2'd1;
	localparam logic [TRIT_W-1:0] TRIT_FALSE   = 2'd2;
	localparam logic [TRIT_W-1:0] TRIT_RSVD    = 2'd3;

	typedef enum logic [1:0] {
		MODE_WRITE = 2'd0,
		MODE_READ  = 2'd1,
		MODE_TRUNC = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ACCESS,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		mode_t               mode;
		logic [FIELD_W-1:0]  index;
		logic [TRIT_W-1:0]   value;
	} req_t;

	typedef struct packed {
		logic [TRIT_W-1:0]   read_trit;
		logic [FIELD_W-1:0]  count_true;
		logic [FIELD_W-1:0]  count_false;
		logic [FIELD_W-1:0]  count_unknown;
		logic [FIELD_W-1:0]  known_length;
		logic                range_error;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic access;
		logic scan;
		logic clear;
		logic out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		mode_t mode;
		logic  in_ok;
		logic  trunc_go;
		logic  need_scan;
		logic  scan_done;
		logic  clear_last;
	} status_t;

endpackage

@@ hdl/pts_stream_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_stream_if
// valid/ready channel carrying one item per handshake
// ----------------------------------------------------------------------------
interface pts_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/packed_trit_store_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_trit_store_unit
// store of CAPACITY three-valued entries with true/false counts and known length
// ----------------------------------------------------------------------------
// req carries one item: mode (write, read, truncate), index and value.
// rsp returns one item per request: the trit read, the true, false and
// unknown counts and the known length after the update, and a range flag.
// Both channels handshake on valid and ready.
// After an item is taken, its path through the states before done is:
//   out-of-range access, mode 3, or truncate at or above the length: none
//   read, or write that does not clear the top entry: access
//   write clearing the top entry at index i above 0: access, then a scan from i - 1
//   truncate at index i below length L: a scan clearing L - 1 down to i
//   both scans stop at the first known entry below, or at entry 0
// The scan reads one memory entry per cycle from the single read port;
// one item is worked on at a time.
// A finished item sits in the rsp register while the next item is taken;
// when rsp is stalled the block holds its next result until the register
// frees up.
// After reset every entry is cleared by a pass over all CAPACITY entries,
// one entry a cycle, with req.ready low.
// ----------------------------------------------------------------------------
`include "packed_trit_store_unit_macros.svh"

module packed_trit_store_unit
	import pts_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	pts_stream_if.sink         req,
	pts_stream_if.source       rsp
);
	cmd_t    cmd;
	status_t st;
	req_t    req_data;
	rsp_t    rsp_data;

	assign req_data = req.data;
	assign rsp.data = rsp_data;

	pts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.rsp_valid(rsp.valid),
		.rsp_ready(rsp.ready),
		.st       (st),
		.cmd      (cmd)
	);

	pts_dp #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.req_data(req_data),
		.st      (st),
		.rsp_data(rsp_data)
	);

	`PTS_ASSERT_NEXT(a_busy_after_load, cmd.load, !req.ready)
	`PTS_ASSERT_NOW(a_no_accept_in_clear, cmd.clear, !req.ready)
	`PTS_ASSERT_NEXT(a_result_shown, cmd.out_load, rsp.valid)
endmodule

@@ hdl/pts_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_ram
// generic memory, one write port and one read port with registered read data
// ----------------------------------------------------------------------------
module pts_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ hdl/pts_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_ctrl
// sequencer: clearing pass, access, downward scan and result hand-off
// ----------------------------------------------------------------------------
module pts_ctrl
	import pts_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	output logic    req_ready,
	output logic    rsp_valid,
	input  logic    rsp_ready,
	input  status_t st,
	output cmd_t    cmd
);
	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || rsp_ready;
	assign rsp_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (st.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_valid) begin
					unique case (st.mode) inside
						MODE_WRITE, MODE_READ: state_d = st.in_ok ? ST_ACCESS : ST_DONE;
						MODE_TRUNC:            state_d = st.trunc_go ? ST_SCAN : ST_DONE;
						default:               state_d = ST_DONE;
					endcase
				end
			end
			ST_ACCESS: begin
				state_d = st.need_scan ? ST_SCAN : ST_DONE;
			end
			ST_SCAN: begin
				if (st.scan_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		req_ready    = (state_q == ST_IDLE);
		cmd.load     = (state_q == ST_IDLE) && req_valid;
		cmd.access   = (state_q == ST_ACCESS);
		cmd.scan     = (state_q == ST_SCAN);
		cmd.clear    = (state_q == ST_CLEAR);
		cmd.out_load = (state_q == ST_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

@@ hdl/pts_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_dp
// trit memory, true/false counters, known length and the result register
// ----------------------------------------------------------------------------
module pts_dp
	import pts_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cmd_t    cmd,
	input  req_t    req_data,
	output status_t st,
	output rsp_t    rsp_data
);
	localparam int AW   = $clog2(CAPACITY);
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > FIELD_W) ? CW : FIELD_W;

	logic [CMPW-1:0]   idx_in;
	logic [TRIT_W-1:0] val_in;

	mode_t             mode_q;
	logic [AW-1:0]     idx_q;
	logic [TRIT_W-1:0] val_q;
	logic [TRIT_W-1:0] rd_q;
	logic              err_q;
	logic [CW-1:0]     len_q;
	logic [CW-1:0]     tcnt_q;
	logic [CW-1:0]     fcnt_q;
	logic [AW-1:0]     scan_addr_q;
	logic              vld_s1;
	logic [AW-1:0]     addr_s1;
	rsp_t              rsp_q;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [TRIT_W-1:0] ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [TRIT_W-1:0] ram_rdata;

	logic              wr_acc;
	logic [CW-1:0]     idx_p1;
	logic              grow;
	logic              top_clr;
	logic              clr_hit;
	logic              found;
	logic              bottom;
	logic              old_hit;
	logic              t_dec, t_inc, f_dec, f_inc;

	assign idx_in = CMPW'(req_data.index);
	assign val_in = (req_data.value == TRIT_RSVD) ? TRIT_UNKNOWN : req_data.value;

	assign wr_acc  = cmd.access && (mode_q == MODE_WRITE);
	assign idx_p1  = CW'(idx_q) + CW'(1'b1);
	assign grow    = wr_acc && (val_q != TRIT_UNKNOWN) && (idx_p1 > len_q);
	assign top_clr = wr_acc && (ram_rdata != TRIT_UNKNOWN) && (val_q == TRIT_UNKNOWN)
		&& (idx_p1 == len_q);

	// entries at or above idx_q are cleared, below it the first known entry ends the scan
	assign clr_hit = cmd.scan && vld_s1 && (addr_s1 >= idx_q);
	assign found   = cmd.scan && vld_s1 && !clr_hit && (ram_rdata != TRIT_UNKNOWN);
	assign bottom  = cmd.scan && vld_s1 && (addr_s1 == '0);

	assign old_hit = wr_acc || clr_hit;
	assign t_dec   = old_hit && (ram_rdata == TRIT_TRUE);
	assign f_dec   = old_hit && (ram_rdata == TRIT_FALSE);
	assign t_inc   = wr_acc && (val_q == TRIT_TRUE);
	assign f_inc   = wr_acc && (val_q == TRIT_FALSE);

	always_comb begin
		st.mode       = req_data.mode;
		st.in_ok      = idx_in < CMPW'(CAPACITY);
		st.trunc_go   = idx_in < CMPW'(len_q);
		st.need_scan  = top_clr && (idx_q != '0);
		st.scan_done  = found || bottom;
		st.clear_last = (scan_addr_q == '0);
	end

	always_comb begin
		ram_we    = cmd.clear || wr_acc || clr_hit;
		ram_wdata = cmd.access ? val_q : TRIT_UNKNOWN;
		if (cmd.clear) begin
			ram_waddr = scan_addr_q;
		end else if (cmd.access) begin
			ram_waddr = idx_q;
		end else begin
			ram_waddr = addr_s1;
		end
		ram_raddr = cmd.scan ? scan_addr_q : idx_in[AW-1:0];
	end

	pts_ram #(
		.WIDTH(TRIT_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			tcnt_q      <= '0;
			fcnt_q      <= '0;
			scan_addr_q <= AW'(CAPACITY - 1);
			vld_s1      <= 1'b0;
		end else begin
			tcnt_q <= tcnt_q - CW'(t_dec) + CW'(t_inc);
			fcnt_q <= fcnt_q - CW'(f_dec) + CW'(f_inc);

			if (grow) begin
				len_q <= idx_p1;
			end else if (top_clr) begin
				len_q <= CW'(idx_q);
			end else if (found) begin
				len_q <= CW'(addr_s1) + CW'(1'b1);
			end else if (bottom) begin
				len_q <= '0;
			end

			if (cmd.clear || cmd.scan) begin
				scan_addr_q <= scan_addr_q - 1'b1;
			end else if (cmd.load) begin
				scan_addr_q <= AW'(len_q - 1'b1);
			end else if (cmd.access) begin
				scan_addr_q <= idx_q - 1'b1;
			end

			vld_s1 <= cmd.scan;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= scan_addr_q;
		if (cmd.load) begin
			mode_q <= req_data.mode;
			idx_q  <= idx_in[AW-1:0];
			val_q  <= val_in;
			rd_q   <= TRIT_UNKNOWN;
			err_q  <= ((req_data.mode == MODE_WRITE) || (req_data.mode == MODE_READ))
				&& !st.in_ok;
		end else if (cmd.access && (mode_q == MODE_READ)) begin
			rd_q <= ram_rdata;
		end
		if (cmd.out_load) begin
			rsp_q.read_trit     <= rd_q;
			rsp_q.count_true    <= FIELD_W'(tcnt_q);
			rsp_q.count_false   <= FIELD_W'(fcnt_q);
			rsp_q.count_unknown <= FIELD_W'(len_q - tcnt_q - fcnt_q);
			rsp_q.known_length  <= FIELD_W'(len_q);
			rsp_q.range_error   <= err_q;
		end
	end

	assign rsp_data = rsp_q;
endmodule
